FILE: rtl/ptm_pkg.sv
`timescale 1ns / 1ps
// package for the page table mapper: sizes, entry bits, function codes, fsm states
// no dependencies
package ptm_pkg;
   localparam int MEM_PAGES = 256;
   localparam int PAGE_BITS = $clog2(MEM_PAGES);
   localparam int WORD_BITS = 9;
   localparam int ADDR_BITS = PAGE_BITS + WORD_BITS;
   localparam int MEM_DEPTH = MEM_PAGES * 512;

   localparam logic [63:0] FRAME_MASK = 64'h000f_ffff_ffff_f000;
   localparam int BIT_P = 0;
   localparam int BIT_W = 1;
   localparam int BIT_U = 2;
   localparam int BIT_H = 7;
   localparam logic [47:0] USER_TOP = 48'h7fff_ffff_ffff;

   typedef enum logic [2:0] {
      FN_MAP = 3'd0, FN_UNMAP = 3'd1, FN_PROTECT = 3'd2, FN_TRANSLATE = 3'd3,
      FN_CHECK = 3'd4, FN_FREE = 3'd5, FN_ALLOC = 3'd6, FN_NONE = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      CSR_ROOT = 2'd0, CSR_FIRST = 2'd1, CSR_END = 2'd2, CSR_NONE = 2'd3
   } csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WALK_RD, ST_WALK_EV, ST_LEAF_EV, ST_ALLOC_RD,
      ST_ALLOC_EV, ST_ZERO, ST_LINK, ST_FREE_WR, ST_DONE
   } state_type;
endpackage

FILE: rtl/ptm_ram.sv
`timescale 1ns / 1ps
// generic single-port synchronous ram with registered read
// no dependencies
module ptm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: rtl/page_table_mapper_with_page_pool_top.sv
`timescale 1ns / 1ps
// page table mapper top level: sequencer around one page memory
// depends on ptm_pkg and ptm_ram
//
// usage: a request (req_func, addresses, flags) enters on req_valid when req_stall is low.
// exactly one response (rsp_status, rsp_result_addr) leaves per request on rsp_valid,
// held while rsp_stall is high; the next request is taken the cycle after the response
// leaves, so one request is in flight at a time.
// sequence: each table level is a read state then an evaluate state through the single
// memory port; a map that creates tables allocates each new table from the free list or
// the bump pointer, zeroes its page word by word and links it; an allocate takes and zeroes
// a page; a free pushes a valid page onto the free list.
// reset: after reset the block sweeps the whole page memory to zero, one word a
// cycle, with req_stall high; csr writes are taken throughout.
// csr: csr_index 0 root page, 1 region first page (loads the bump pointer),
// 2 region end page; written while idle.
module page_table_mapper_with_page_pool_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [47:0] req_virt_addr,
   input  logic [51:0] req_phys_addr,
   input  logic        req_writable,
   input  logic        req_user_access,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [51:0] rsp_result_addr,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   localparam int PB = ptm_pkg::PAGE_BITS;
   localparam int AB = ptm_pkg::ADDR_BITS;

   ptm_pkg::state_type state_ff, state_in;
   logic [AB-1:0] clr_ff, clr_in;
   logic [7:0]  root_ff;
   logic [8:0]  end_ff, bump_ff, bump_in;
   logic [PB-1:0] head_ff, head_in;
   ptm_pkg::func_type func_ff;
   logic [47:0] va_ff;
   logic [51:0] pa_ff;
   logic wr_ff, usr_ff;
   logic [1:0] lvl_ff, lvl_in;
   logic [PB-1:0] table_ff, table_in;
   logic [PB-1:0] np_ff, np_in;
   logic [8:0] zidx_ff, zidx_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_status_ff, rsp_status_in;
   logic [51:0] rsp_addr_ff, rsp_addr_in;
   logic [PB-1:0] fpage_ff, fpage_in;

   logic mem_we;
   logic [AB-1:0] mem_addr;
   logic [63:0] mem_wd, rd;

   ptm_ram #(.WIDTH(64), .DEPTH(ptm_pkg::MEM_DEPTH)) u_mem (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(mem_wd), .rd_data(rd)
   );

   logic accept;
   logic [8:0] idx;
   logic create;
   logic [51:0] nxt_tab;
   logic [51:0] link_nxt;
   logic free_ok;
   logic [51:0] pa_pg;

   assign req_stall = (state_ff != ptm_pkg::ST_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign create = (func_ff == ptm_pkg::FN_MAP);

   always_comb begin
      unique case (lvl_ff)
         2'd3: idx = va_ff[47:39];
         2'd2: idx = va_ff[38:30];
         2'd1: idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign nxt_tab = {12'd0, rd[51:12]};
   assign link_nxt = {12'd0, rd[51:12]};
   assign pa_pg = {12'd0, pa_ff[51:12]};
   assign free_ok = (pa_ff != 52'd0) && (pa_ff[11:0] == 12'd0) &&
                    (pa_pg < 52'(ptm_pkg::MEM_PAGES));

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      head_in = head_ff;
      bump_in = bump_ff;
      lvl_in = lvl_ff;
      table_in = table_ff;
      np_in = np_ff;
      zidx_in = zidx_ff;
      fpage_in = fpage_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      mem_we = 1'b0;
      mem_addr = {table_ff, idx};
      mem_wd = 64'd0;
      if (csr_valid && ptm_pkg::csr_type'(csr_index) == ptm_pkg::CSR_FIRST) begin
         bump_in = csr_wdata;
      end
      unique case (state_ff)
         ptm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AB'(ptm_pkg::MEM_DEPTH - 1)) state_in = ptm_pkg::ST_IDLE;
         end
         ptm_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_status_in = 1'b1;
               rsp_addr_in = 52'd0;
               lvl_in = 2'd3;
               table_in = root_ff[PB-1:0];
               priority case (ptm_pkg::func_type'(req_func))
                  ptm_pkg::FN_FREE: state_in = ptm_pkg::ST_FREE_WR;
                  ptm_pkg::FN_ALLOC: state_in = ptm_pkg::ST_ALLOC_RD;
                  ptm_pkg::FN_NONE: state_in = ptm_pkg::ST_DONE;
                  ptm_pkg::FN_CHECK: state_in = (req_virt_addr <= ptm_pkg::USER_TOP) ?
                                          ptm_pkg::ST_WALK_RD : ptm_pkg::ST_DONE;
                  default: state_in = ptm_pkg::ST_WALK_RD;
               endcase
            end
         end
         ptm_pkg::ST_WALK_RD: begin
            state_in = (lvl_ff == 2'd0) ? ptm_pkg::ST_LEAF_EV : ptm_pkg::ST_WALK_EV;
         end
         ptm_pkg::ST_WALK_EV: begin
            if (!rd[ptm_pkg::BIT_P]) begin
               if (!create) state_in = ptm_pkg::ST_DONE;
               else state_in = ptm_pkg::ST_ALLOC_RD;
            end else if (rd[ptm_pkg::BIT_H]) begin
               state_in = ptm_pkg::ST_DONE;
            end else begin
               if (create && usr_ff) begin
                  mem_we = 1'b1;
                  mem_wd = rd | 64'(1 << ptm_pkg::BIT_U);
               end
               if (nxt_tab >= 52'(ptm_pkg::MEM_PAGES)) begin
                  state_in = ptm_pkg::ST_DONE;
               end else begin
                  table_in = nxt_tab[PB-1:0];
                  lvl_in = lvl_ff - 1'b1;
                  state_in = ptm_pkg::ST_WALK_RD;
               end
            end
         end
         ptm_pkg::ST_ALLOC_RD: begin
            // read word 0 of the free-list head for its link
            mem_addr = {head_ff, 9'd0};
            state_in = ptm_pkg::ST_ALLOC_EV;
         end
         ptm_pkg::ST_ALLOC_EV: begin
            zidx_in = 9'd0;
            if (head_ff != '0) begin
               np_in = head_ff;
               head_in = (link_nxt < 52'(ptm_pkg::MEM_PAGES)) ? link_nxt[PB-1:0] : '0;
               state_in = ptm_pkg::ST_ZERO;
            end else if (bump_ff != 9'd0 && bump_ff < end_ff &&
                         32'(bump_ff) < ptm_pkg::MEM_PAGES) begin
               np_in = bump_ff[PB-1:0];
               bump_in = bump_ff + 1'b1;
               state_in = ptm_pkg::ST_ZERO;
            end else begin
               state_in = ptm_pkg::ST_DONE;
            end
         end
         ptm_pkg::ST_ZERO: begin
            mem_we = 1'b1;
            mem_addr = {np_ff, zidx_ff};
            zidx_in = zidx_ff + 1'b1;
            if (zidx_ff == 9'h1ff) begin
               if (func_ff == ptm_pkg::FN_ALLOC) begin
                  rsp_status_in = 1'b0;
                  rsp_addr_in = {{(40-PB){1'b0}}, np_ff, 12'd0};
                  state_in = ptm_pkg::ST_DONE;
               end else begin
                  state_in = ptm_pkg::ST_LINK;
               end
            end
         end
         ptm_pkg::ST_LINK: begin
            // enter the new table in the parent entry and descend
            mem_we = 1'b1;
            mem_wd = {12'd0, {(40-PB){1'b0}}, np_ff, 12'd0} | 64'h3 |
                     (usr_ff ? 64'h4 : 64'h0);
            table_in = np_ff;
            lvl_in = lvl_ff - 1'b1;
            state_in = ptm_pkg::ST_WALK_RD;
         end
         ptm_pkg::ST_LEAF_EV: begin
            state_in = ptm_pkg::ST_DONE;
            if (create) begin
               mem_we = 1'b1;
               mem_wd = {12'd0, pa_ff & ptm_pkg::FRAME_MASK[51:0]} | 64'h1 |
                        (usr_ff ? 64'h4 : 64'h0) | (wr_ff ? 64'h2 : 64'h0);
               rsp_status_in = 1'b0;
            end else if (rd[ptm_pkg::BIT_P] && rd[ptm_pkg::BIT_U]) begin
               unique case (func_ff)
                  ptm_pkg::FN_UNMAP: begin
                     mem_we = 1'b1;
                     rsp_status_in = 1'b0;
                     if (rd[51:12] != 40'd0 && {12'd0, rd[51:12]} <
                         52'(ptm_pkg::MEM_PAGES)) begin
                        fpage_in = rd[12 +: PB];
                        state_in = ptm_pkg::ST_FREE_WR;
                     end
                  end
                  ptm_pkg::FN_PROTECT: begin
                     mem_we = 1'b1;
                     mem_wd = {rd[63:2], wr_ff, rd[0]};
                     rsp_status_in = 1'b0;
                  end
                  ptm_pkg::FN_TRANSLATE: begin
                     rsp_status_in = 1'b0;
                     rsp_addr_in = {rd[51:12], va_ff[11:0]};
                  end
                  default: rsp_status_in = !((!wr_ff) || rd[ptm_pkg::BIT_W]);
               endcase
            end
         end
         ptm_pkg::ST_FREE_WR: begin
            state_in = ptm_pkg::ST_DONE;
            if (func_ff == ptm_pkg::FN_UNMAP) begin
               mem_we = 1'b1;
               mem_addr = {fpage_ff, 9'd0};
               mem_wd = {{(52-PB){1'b0}}, head_ff, 12'd0};
               head_in = fpage_ff;
            end else if (free_ok) begin
               mem_we = 1'b1;
               mem_addr = {pa_ff[12 +: PB], 9'd0};
               mem_wd = {{(52-PB){1'b0}}, head_ff, 12'd0};
               head_in = pa_ff[12 +: PB];
               rsp_status_in = 1'b0;
            end
         end
         ptm_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ptm_pkg::ST_IDLE;
         end
         default: state_in = ptm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptm_pkg::ST_CLEAR;
         clr_ff <= '0;
         root_ff <= 8'd1;
         end_ff <= 9'd256;
         bump_ff <= 9'd2;
         head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         head_ff <= head_in;
         bump_ff <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (ptm_pkg::csr_type'(csr_index))
               ptm_pkg::CSR_ROOT: root_ff <= csr_wdata[7:0];
               // first page only loads the bump pointer, in the next-state logic
               ptm_pkg::CSR_FIRST: ;
               ptm_pkg::CSR_END: end_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= ptm_pkg::func_type'(req_func);
         va_ff <= req_virt_addr;
         pa_ff <= req_phys_addr;
         wr_ff <= req_writable;
         usr_ff <= req_user_access;
      end
      lvl_ff <= lvl_in;
      table_ff <= table_in;
      np_ff <= np_in;
      zidx_ff <= zidx_in;
      fpage_ff <= fpage_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
   end
endmodule
